// ----- rtl/pld_pkg.sv -----
// Shared constants, types and state encoding for the pivot low/high detector.
`timescale 1ns / 1ps
`default_nettype none
package pld_pkg;

  localparam int MAX_WINDOW = 64;
  localparam int PTR_W      = $clog2(MAX_WINDOW);
  localparam int WIN_W      = PTR_W + 1;
  localparam int SAMPLE_W   = 32;
  localparam int CNT_W      = 32;
  localparam int LEFT_W     = 5;
  localparam int RIGHT_W    = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int BAR_W      = 2 * SAMPLE_W;

  localparam logic [LEFT_W-1:0]  LEFT_RESET  = LEFT_W'(5);
  localparam logic [RIGHT_W-1:0] RIGHT_RESET = RIGHT_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEFT_BARS   = 2'd0,
    REG_RIGHT_BARS  = 2'd1,
    REG_DETECT_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } pld_state_e;

  typedef struct packed {
    logic accept;
    logic scan_init;
    logic scan_rd;
    logic finish;
  } pld_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic out_free;
  } pld_status_t;

endpackage
`default_nettype wire

// ----- rtl/pld_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/pld_ctrl.sv -----
// Sequencing state machine: accept, window check, scan, result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pld_ctrl import pld_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire pld_status_t status_i,
  output pld_cmd_t         cmd_o
);

  pld_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EVAL;
      S_EVAL:  state_d = status_i.full ? S_SCAN : S_DONE;
      S_SCAN:  if (status_i.scan_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_DONE;
      S_DONE:  if (status_i.out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      S_EVAL:  cmd_o.scan_init = 1'b1;
      S_SCAN:  cmd_o.scan_rd = 1'b1;
      S_DRAIN: cmd_o = '0;
      S_DONE:  cmd_o.finish = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/pld_dp.sv -----
// Datapath: configuration, bar store, counters, extreme scan and result register.
`timescale 1ns / 1ps
`default_nettype none
module pld_dp import pld_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                   start_of_series_i,
  input  wire logic [SAMPLE_W-1:0]    div_value_i,
  input  wire logic [SAMPLE_W-1:0]    price_value_i,
  input  wire logic                   out_stall_i,
  output logic                        out_valid_o,
  output logic                        window_full_o,
  output logic                        is_pivot_o,
  output logic [CNT_W-1:0]            pivot_bar_index_o,
  output logic [SAMPLE_W-1:0]         pivot_div_value_o,
  output logic [SAMPLE_W-1:0]         pivot_price_o,
  output logic [CNT_W-1:0]            pivot_count_o,
  input  wire pld_cmd_t               cmd_i,
  output pld_status_t                 status_o
);

  logic [LEFT_W-1:0]  left_q;
  logic [RIGHT_W-1:0] right_q;
  logic               high_q;

  logic [PTR_W-1:0] wp_q, newest_q, wp_use;
  logic [CNT_W-1:0] bars_q, pivots_q, bars_base;

  logic [PTR_W-1:0] cnt_q, rd_idx_q;
  logic             rd_v_q;
  logic signed [SAMPLE_W-1:0] ext_q, mid_val_q;
  logic [SAMPLE_W-1:0]        mid_price_q;

  logic             out_valid_q, full_q, pivot_q;
  logic [CNT_W-1:0] index_q, count_q;
  logic [SAMPLE_W-1:0] oval_q, oprice_q;

  logic [WIN_W-1:0] lim, rb_w, win;
  logic [PTR_W-1:0] rb;
  logic [BAR_W-1:0] rdata;
  logic signed [SAMPLE_W-1:0] key;
  logic             better, full, pivot;
  logic [CNT_W-1:0] count_new;

  // window sizes, right side clipped so the window fits the store
  assign lim  = WIN_W'(MAX_WINDOW - 1) - WIN_W'(left_q);
  assign rb_w = (WIN_W'(right_q) > lim) ? lim : WIN_W'(right_q);
  assign rb   = PTR_W'(rb_w);
  assign win  = WIN_W'(left_q) + rb_w + WIN_W'(1);
  assign full = bars_q >= CNT_W'(win);

  assign wp_use    = start_of_series_i ? '0 : wp_q;
  assign bars_base = start_of_series_i ? '0 : bars_q;

  pld_ram #(
    .WIDTH(BAR_W),
    .DEPTH(MAX_WINDOW)
  ) u_bar_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.accept),
    .waddr_i(wp_use),
    .wdata_i({price_value_i, div_value_i}),
    .raddr_i(newest_q - cnt_q),
    .rdata_o(rdata)
  );

  assign key    = $signed(rdata[SAMPLE_W-1:0]);
  assign better = high_q ? (key > ext_q) : (key < ext_q);
  assign pivot  = full && (ext_q == mid_val_q);
  assign count_new = pivots_q + CNT_W'(pivot && (pivots_q != '1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LEFT_RESET;
      right_q <= RIGHT_RESET;
      high_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_LEFT_BARS:   left_q  <= LEFT_W'(cfg_wdata_i);
        REG_RIGHT_BARS:  right_q <= RIGHT_W'(cfg_wdata_i);
        REG_DETECT_HIGH: high_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      newest_q    <= '0;
      bars_q      <= '0;
      pivots_q    <= '0;
      cnt_q       <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        wp_q     <= wp_use + PTR_W'(1);
        newest_q <= wp_use;
        bars_q   <= (bars_base == '1) ? bars_base : bars_base + CNT_W'(1);
        if (start_of_series_i) begin
          pivots_q <= '0;
        end
      end
      if (cmd_i.scan_init) begin
        cnt_q <= '0;
      end else if (cmd_i.scan_rd) begin
        cnt_q <= cnt_q + PTR_W'(1);
      end
      rd_v_q <= cmd_i.scan_rd;
      if (cmd_i.finish) begin
        pivots_q <= count_new;
      end
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= cnt_q;
    if (rd_v_q) begin
      if (rd_idx_q == '0 || better) begin
        ext_q <= key;
      end
      if (rd_idx_q == rb) begin
        mid_val_q   <= key;
        mid_price_q <= rdata[BAR_W-1:SAMPLE_W];
      end
    end
    if (cmd_i.finish) begin
      full_q   <= full;
      pivot_q  <= pivot;
      index_q  <= full ? (bars_q - CNT_W'(1) - CNT_W'(rb_w)) : '0;
      oval_q   <= full ? mid_val_q : '0;
      oprice_q <= full ? mid_price_q : '0;
      count_q  <= count_new;
    end
  end

  assign status_o.full      = full;
  assign status_o.scan_last = (cnt_q == PTR_W'(win - WIN_W'(1)));
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o       = out_valid_q;
  assign window_full_o     = full_q;
  assign is_pivot_o        = pivot_q;
  assign pivot_bar_index_o = index_q;
  assign pivot_div_value_o = oval_q;
  assign pivot_price_o     = oprice_q;
  assign pivot_count_o     = count_q;

endmodule
`default_nettype wire

// ----- rtl/pivot_low_high_detector_unit.sv -----
// Top level of the pivot low/high detector.
// One bar is taken at a time and yields one result item. A bar that does not
// yet fill the window goes from acceptance through the check state straight to
// the done state, and the next bar can be taken once that state is left.
// Otherwise the block reads every bar of the window (W = left_bars +
// right_bars + 1, right_bars clipped so that W is at most 64) from the bar
// store through its single read port, one per cycle, with one signed
// comparator. A drain state follows the scan, and the done state registers
// the result once the output register is free. The store holds no reset
// state. The finished result sits in an output register while the next bar
// is accepted; the following result waits in the done state until the one before it is taken.
`timescale 1ns / 1ps
`default_nettype none
module pivot_low_high_detector_unit import pld_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  start_of_series_i,
  input  wire logic [SAMPLE_W-1:0]   div_value_i,
  input  wire logic [SAMPLE_W-1:0]   price_value_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       window_full_o,
  output logic                       is_pivot_o,
  output logic [CNT_W-1:0]           pivot_bar_index_o,
  output logic [SAMPLE_W-1:0]        pivot_div_value_o,
  output logic [SAMPLE_W-1:0]        pivot_price_o,
  output logic [CNT_W-1:0]           pivot_count_o
);

  pld_cmd_t    cmd;
  pld_status_t status;

  pld_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  pld_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_of_series_i(start_of_series_i),
    .div_value_i      (div_value_i),
    .price_value_i    (price_value_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .window_full_o    (window_full_o),
    .is_pivot_o       (is_pivot_o),
    .pivot_bar_index_o(pivot_bar_index_o),
    .pivot_div_value_o(pivot_div_value_o),
    .pivot_price_o    (pivot_price_o),
    .pivot_count_o    (pivot_count_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule
`default_nettype wire

// ----- rtl/pld_checker.sv -----
// Port-level checks for the pivot low/high detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pld_checker import pld_pkg::*; (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_stall_o,
  input wire logic                out_valid_o,
  input wire logic                out_stall_i,
  input wire logic                window_full_o,
  input wire logic                is_pivot_o,
  input wire logic [CNT_W-1:0]    pivot_count_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pivot_count_o))
    else $error("result item changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("new item accepted while one is in work");

  a_pivot_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_pivot_o |-> window_full_o)
    else $error("pivot reported before window full");

  a_pivot_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_pivot_o |-> pivot_count_o != '0)
    else $error("pivot reported with zero pivot count");

endmodule

bind pivot_low_high_detector_unit pld_checker u_pld_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .window_full_o(window_full_o),
  .is_pivot_o   (is_pivot_o),
  .pivot_count_o(pivot_count_o)
);
`default_nettype wire

// ----- dv/pld_pivot_checker.sv -----
// Checker for the pivot detector: predicts every result item and compares it field by field.
`timescale 1ns / 1ps
module pld_pivot_checker import pld_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  start_of_series_i,
  input  logic [SAMPLE_W-1:0]   div_value_i,
  input  logic [SAMPLE_W-1:0]   price_value_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic                  window_full_i,
  input  logic                  is_pivot_i,
  input  logic [CNT_W-1:0]      pivot_bar_index_i,
  input  logic [SAMPLE_W-1:0]   pivot_div_value_i,
  input  logic [SAMPLE_W-1:0]   pivot_price_i,
  input  logic [CNT_W-1:0]      pivot_count_i,
  output int                    error_count_o,
  output int                    pending_o
);

  typedef struct {
    logic                       window_full;
    logic                       is_pivot;
    logic [CNT_W-1:0]           bar_index;
    logic signed [SAMPLE_W-1:0] div_value;
    logic signed [SAMPLE_W-1:0] price;
    logic [CNT_W-1:0]           count;
  } pivot_result_t;

  logic signed [SAMPLE_W-1:0] div_store   [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] price_store [MAX_WINDOW];
  logic [PTR_W-1:0]           slot_next;
  logic [CNT_W-1:0]           bars_seen;
  logic [CNT_W-1:0]           pivots_found;
  logic [LEFT_W-1:0]          left_bars;
  logic [RIGHT_W-1:0]         right_bars;
  logic                       detect_high;
  pivot_result_t              pivot_results_q [$];
  pivot_result_t              oldest;

  // Takes one bar into the store and judges the window's candidate bar, rb bars back from the newest.
  function automatic pivot_result_t judge_bar(input logic sos,
                                              input logic signed [SAMPLE_W-1:0] div,
                                              input logic signed [SAMPLE_W-1:0] price);
    int                         lb;
    int                         rb;
    int                         w;
    logic [PTR_W-1:0]           newest;
    logic [PTR_W-1:0]           mid;
    logic [PTR_W-1:0]           slot;
    logic signed [SAMPLE_W-1:0] extreme;
    pivot_result_t              r;
    if (sos) begin
      bars_seen    = '0;
      pivots_found = '0;
      slot_next    = '0;
    end
    newest              = slot_next;
    div_store[newest]   = div;
    price_store[newest] = price;
    slot_next           = slot_next + 1'b1;
    if (bars_seen != '1) bars_seen = bars_seen + 1'b1;

    lb = int'(left_bars);
    rb = int'(right_bars);
    if (rb > MAX_WINDOW - 1 - lb) rb = MAX_WINDOW - 1 - lb;
    w = lb + rb + 1;

    r.window_full = 1'b0;
    r.is_pivot    = 1'b0;
    r.bar_index   = '0;
    r.div_value   = '0;
    r.price       = '0;
    if (bars_seen >= CNT_W'(w)) begin
      mid     = newest - PTR_W'(rb);
      extreme = div_store[mid];
      for (int i = 0; i < w; i++) begin
        slot = newest - PTR_W'(i);
        if (detect_high ? (div_store[slot] > extreme) : (div_store[slot] < extreme))
          extreme = div_store[slot];
      end
      r.window_full = 1'b1;
      r.is_pivot    = (extreme == div_store[mid]);
      if (r.is_pivot && pivots_found != '1) pivots_found = pivots_found + 1'b1;
      r.bar_index = bars_seen - 1'b1 - CNT_W'(rb);
      r.div_value = div_store[mid];
      r.price     = price_store[mid];
    end
    r.count = pivots_found;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_next     = '0;
      bars_seen     = '0;
      pivots_found  = '0;
      left_bars     = LEFT_RESET;
      right_bars    = RIGHT_RESET;
      detect_high   = 1'b0;
      error_count_o = 0;
      pivot_results_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pivot_results_q.size() == 0) begin
          $error("result item with no expected result waiting");
          error_count_o++;
        end else begin
          oldest = pivot_results_q.pop_front();
          check_field("window_full", 32'(oldest.window_full), 32'(window_full_i));
          check_field("is_pivot", 32'(oldest.is_pivot), 32'(is_pivot_i));
          check_field("pivot_bar_index", oldest.bar_index, pivot_bar_index_i);
          check_field("pivot_div_value", oldest.div_value, pivot_div_value_i);
          check_field("pivot_price", oldest.price, pivot_price_i);
          check_field("pivot_count", oldest.count, pivot_count_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        pivot_results_q.push_back(judge_bar(start_of_series_i, div_value_i, price_value_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LEFT_BARS:   left_bars   = cfg_wdata_i[LEFT_W-1:0];
          REG_RIGHT_BARS:  right_bars  = cfg_wdata_i[RIGHT_W-1:0];
          REG_DETECT_HIGH: detect_high = cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
    pending_o = pivot_results_q.size();
  end

endmodule

// ----- dv/pivot_low_high_detector_unit_test.sv -----
// Testbench top for the pivot detector: bar stimulus, register writes, idling and verdict.
`timescale 1ns / 1ps
module pivot_low_high_detector_unit_test;
  import pld_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MIN = 32'h8000_0000;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX = 32'h7fff_ffff;
  localparam int                   BAR_TARGET = 2000;
  localparam int                   IDLE_LIMIT = 2000;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic                  bar_sos     = 1'b0;
  logic [SAMPLE_W-1:0]   bar_div     = '0;
  logic [SAMPLE_W-1:0]   bar_price   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic                  window_full;
  logic                  is_pivot;
  logic [CNT_W-1:0]      pivot_bar_index;
  logic [SAMPLE_W-1:0]   pivot_div_value;
  logic [SAMPLE_W-1:0]   pivot_price;
  logic [CNT_W-1:0]      pivot_count;
  int                    error_count;
  int                    pending;
  int                    bars_sent   = 0;
  int                    quiet_cycles = 0;
  logic                  calm        = 1'b0;
  logic [SAMPLE_W-1:0]   walk_level  = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pivot_low_high_detector_unit i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .start_of_series_i (bar_sos),
    .div_value_i       (bar_div),
    .price_value_i     (bar_price),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .window_full_o     (window_full),
    .is_pivot_o        (is_pivot),
    .pivot_bar_index_o (pivot_bar_index),
    .pivot_div_value_o (pivot_div_value),
    .pivot_price_o     (pivot_price),
    .pivot_count_o     (pivot_count)
  );

  pld_pivot_checker i_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .start_of_series_i (bar_sos),
    .div_value_i       (bar_div),
    .price_value_i     (bar_price),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .window_full_i     (window_full),
    .is_pivot_i        (is_pivot),
    .pivot_bar_index_i (pivot_bar_index),
    .pivot_div_value_i (pivot_div_value),
    .pivot_price_i     (pivot_price),
    .pivot_count_i     (pivot_count),
    .error_count_o     (error_count),
    .pending_o         (pending)
  );

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  initial begin
    int len;
    forever begin
      @(negedge clk_i);
      len = pick_gap();
      if (len > 0) begin
        out_stall <= 1'b1;
        repeat (len) @(negedge clk_i);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(0, 5)) @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IDLE_LIMIT) begin
      $display("pivot_low_high_detector_unit: mismatch");
      $finish;
    end
  end

  // called and returns at a falling edge; valid stays high after the item
  task automatic send_bar(input logic sos, input logic [SAMPLE_W-1:0] div,
                          input logic [SAMPLE_W-1:0] price);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid  <= 1'b1;
    bar_sos   <= sos;
    bar_div   <= div;
    bar_price <= price;
    do @(posedge clk_i); while (in_stall);
    bars_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
  endtask

  // unused upper data bits are randomized; returns the effective window size
  task automatic set_sizes(input int lb, input int rb, input logic high, output int w);
    int rb_eff;
    drain();
    write_reg(REG_LEFT_BARS, {1'($urandom), LEFT_W'(lb)});
    write_reg(REG_RIGHT_BARS, RIGHT_W'(rb));
    write_reg(REG_DETECT_HIGH, {5'($urandom), high});
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    rb_eff = (rb > MAX_WINDOW - 1 - lb) ? MAX_WINDOW - 1 - lb : rb;
    w = lb + rb_eff + 1;
  endtask

  task automatic run_series(input int n, input logic fresh);
    int                  style;
    logic [SAMPLE_W-1:0] div;
    style = $urandom_range(0, 3);
    walk_level = $urandom;
    for (int k = 0; k < n; k++) begin
      case (style)
        0: div = $urandom;
        1: div = 32'($urandom_range(0, 6)) - 32'd3;
        2: begin
          walk_level = walk_level + 32'($urandom_range(0, 8)) - 32'd4;
          div = walk_level;
        end
        default: begin
          case ($urandom_range(0, 4))
            0: div = SAMPLE_MIN;
            1: div = SAMPLE_MAX;
            2: div = '0;
            3: div = '1;
            default: div = $urandom;
          endcase
        end
      endcase
      send_bar((k == 0 && fresh) || $urandom_range(0, 49) == 0, div, $urandom);
    end
  endtask

  initial begin
    int w;
    int lb;
    int rb;
    int n;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset sizes: window never fills here
    send_bar(1'b1, SAMPLE_MIN, SAMPLE_MAX);
    send_bar(1'b0, SAMPLE_MAX, SAMPLE_MIN);
    send_bar(1'b0, '0, '1);

    // single-bar window: every bar is a pivot
    set_sizes(0, 0, 1'b0, w);
    send_bar(1'b0, '1, '0);
    send_bar(1'b1, 32'd1, SAMPLE_MAX);

    drain();
    write_reg(REG_SPARE, '1);
    cfg_we <= 1'b0;

    // low mode with ties and extremes
    set_sizes(1, 1, 1'b0, w);
    send_bar(1'b1, 32'd5, $urandom);
    send_bar(1'b0, 32'd5, $urandom);
    send_bar(1'b0, 32'd5, $urandom);
    send_bar(1'b0, SAMPLE_MIN, $urandom);
    send_bar(1'b0, SAMPLE_MAX, $urandom);
    send_bar(1'b0, SAMPLE_MIN, $urandom);
    send_bar(1'b0, '0, $urandom);
    send_bar(1'b0, '1, $urandom);

    // mode and size changes within the series
    set_sizes(1, 1, 1'b1, w);
    send_bar(1'b0, SAMPLE_MAX, $urandom);
    send_bar(1'b0, SAMPLE_MAX, $urandom);
    send_bar(1'b0, -32'sd7, $urandom);
    set_sizes(2, 0, 1'b1, w);
    send_bar(1'b0, 32'd3, $urandom);
    send_bar(1'b0, 32'd9, $urandom);

    while (bars_sent < BAR_TARGET) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13: begin
          lb = $urandom_range(0, 3);
          rb = $urandom_range(0, 3);
        end
        14, 15, 16: begin
          lb = $urandom_range(0, 31);
          rb = $urandom_range(0, 20);
        end
        default: begin
          case ($urandom_range(0, 4))
            0: begin lb = 31; rb = 32; end
            1: begin lb = 31; rb = 63; end
            2: begin lb = 0;  rb = 63; end
            3: begin lb = 31; rb = 0;  end
            default: begin lb = 0; rb = 0; end
          endcase
        end
      endcase
      set_sizes(lb, rb, 1'($urandom), w);
      calm = ($urandom_range(0, 4) == 0);
      n = w + ((w > 24) ? $urandom_range(1, 8) : $urandom_range(4, 40));
      run_series(n, $urandom_range(0, 4) != 0);
    end

    calm = 1'b0;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
    if (error_count == 0 && pending == 0) begin
      $display("pivot_low_high_detector_unit: match");
    end else begin
      $display("pivot_low_high_detector_unit: mismatch");
    end
    $finish;
  end

endmodule
